### hdl/psu_pkg.sv
// ============================================================================
// psu_pkg
// Shared types, codes and helpers for the PNG scanline unfilter / RGB565 unit.
// ============================================================================
package psu_pkg;

    // Sizing
    localparam int MAX_WIDTH     = 256;
    localparam int MAX_BPP       = 4;
    localparam int PALETTE_DEPTH = 256;
    localparam int CROP_MAX      = 256;
    localparam int LINE_DEPTH    = MAX_WIDTH * MAX_BPP;
    localparam int LINE_AW       = $clog2(LINE_DEPTH);
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int POS_W         = 11;
    localparam int ROW_W         = 9;

    // Operation codes
    localparam logic [1:0] OP_STREAM = 2'd0;
    localparam logic [1:0] OP_PAL_WR = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    // Color modes
    localparam logic [2:0] MODE_GRAY = 3'd0;
    localparam logic [2:0] MODE_RGB  = 3'd1;
    localparam logic [2:0] MODE_PAL  = 3'd2;
    localparam logic [2:0] MODE_GA   = 3'd3;
    localparam logic [2:0] MODE_RGBA = 3'd4;

    // Filter types
    localparam logic [7:0] FLT_SUB   = 8'd1;
    localparam logic [7:0] FLT_UP    = 8'd2;
    localparam logic [7:0] FLT_AVG   = 8'd3;
    localparam logic [7:0] FLT_PAETH = 8'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_MODE    = 3'd1;
    localparam logic [2:0] CFG_PAL_CNT = 3'd2;
    localparam logic [2:0] CFG_CROP_X  = 3'd3;
    localparam logic [2:0] CFG_CROP_Y  = 3'd4;
    localparam logic [2:0] CFG_CROP_W  = 3'd5;
    localparam logic [2:0] CFG_CROP_H  = 3'd6;

    // RGB565 masks
    localparam logic [7:0] R_MASK = 8'hF8;
    localparam logic [7:0] G_MASK = 8'hFC;

    // Effective configuration, derived from the register file
    typedef struct packed {
        logic [2:0]       mode;
        logic [2:0]       bpp;
        logic [POS_W-1:0] row_bytes;
        logic [7:0]       crop_x;
        logic [7:0]       crop_y;
        logic [9:0]       x_end;
        logic [9:0]       y_end;
        logic [8:0]       pal_count;
    } t_cfg;

    // Completed pixel inside the crop window
    typedef struct packed {
        logic       vld;
        logic [7:0] pix0;
        logic [7:0] pix1;
        logic [7:0] pix2;
        logic [7:0] col;
        logic [7:0] row;
        logic       last;
        logic       done;
    } t_pix_evt;

    // Palette entry write
    typedef struct packed {
        logic       we;
        logic [7:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pal_wr;

    function automatic logic [2:0] bpp_of(input logic [2:0] mode);
        logic [2:0] res;
        case (mode)
            MODE_RGB:  res = 3'd3;
            MODE_PAL:  res = 3'd1;
            MODE_GA:   res = 3'd2;
            MODE_RGBA: res = 3'd4;
            default:   res = 3'd1;
        endcase
        return res;
    endfunction

    // RGB565 with the two bytes swapped
    function automatic logic [15:0] to_565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        logic [7:0]  rm;
        logic [7:0]  gm;
        logic [15:0] c;
        rm = r & R_MASK;
        gm = g & G_MASK;
        c  = {rm[7:3], gm[7:2], b[7:3]};
        return {c[7:0], c[15:8]};
    endfunction

endpackage

### hdl/psu_cfg.sv
// ============================================================================
// psu_cfg
// Configuration register file with clamping and derived crop/row limits.
// ============================================================================
module psu_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data,
    output psu_pkg::t_cfg       o_cfg
);

    logic [8:0] r_width;
    logic [2:0] r_mode;
    logic [8:0] r_pal_cnt;
    logic [7:0] r_crop_x;
    logic [7:0] r_crop_y;
    logic [8:0] r_crop_w;
    logic [8:0] r_crop_h;

    logic [8:0] w_eff;
    logic [8:0] cw;
    logic [8:0] ch;
    logic [2:0] mode_eff;
    logic [2:0] bpp;
    logic [9:0] x_sum;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= 9'(psu_pkg::MAX_WIDTH);
            r_mode    <= psu_pkg::MODE_GRAY;
            r_pal_cnt <= 9'd0;
            r_crop_x  <= 8'd0;
            r_crop_y  <= 8'd0;
            r_crop_w  <= 9'(psu_pkg::CROP_MAX);
            r_crop_h  <= 9'(psu_pkg::CROP_MAX);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                psu_pkg::CFG_WIDTH:   r_width   <= i_cfg_data;
                psu_pkg::CFG_MODE:    r_mode    <= i_cfg_data[2:0];
                psu_pkg::CFG_PAL_CNT: r_pal_cnt <= i_cfg_data;
                psu_pkg::CFG_CROP_X:  r_crop_x  <= i_cfg_data[7:0];
                psu_pkg::CFG_CROP_Y:  r_crop_y  <= i_cfg_data[7:0];
                psu_pkg::CFG_CROP_W:  r_crop_w  <= i_cfg_data;
                psu_pkg::CFG_CROP_H:  r_crop_h  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp and derive
    always_comb begin
        if (r_width == 9'd0)
            w_eff = 9'd1;
        else if (r_width > 9'(psu_pkg::MAX_WIDTH))
            w_eff = 9'(psu_pkg::MAX_WIDTH);
        else
            w_eff = r_width;

        if (r_crop_w == 9'd0)
            cw = 9'd1;
        else if (r_crop_w > 9'(psu_pkg::CROP_MAX))
            cw = 9'(psu_pkg::CROP_MAX);
        else
            cw = r_crop_w;

        if (r_crop_h == 9'd0)
            ch = 9'd1;
        else if (r_crop_h > 9'(psu_pkg::CROP_MAX))
            ch = 9'(psu_pkg::CROP_MAX);
        else
            ch = r_crop_h;

        mode_eff = (r_mode > psu_pkg::MODE_RGBA) ? psu_pkg::MODE_GRAY : r_mode;
        bpp      = psu_pkg::bpp_of(mode_eff);

        x_sum = {2'b00, r_crop_x} + {1'b0, cw};

        o_cfg.mode = mode_eff;
        o_cfg.bpp  = bpp;
        case (bpp)
            3'd2:    o_cfg.row_bytes = {psu_pkg::POS_W'(w_eff)} << 1;
            3'd3:    o_cfg.row_bytes = (psu_pkg::POS_W'(w_eff) << 1)
                                     + psu_pkg::POS_W'(w_eff);
            3'd4:    o_cfg.row_bytes = psu_pkg::POS_W'(w_eff) << 2;
            default: o_cfg.row_bytes = psu_pkg::POS_W'(w_eff);
        endcase
        o_cfg.crop_x    = r_crop_x;
        o_cfg.crop_y    = r_crop_y;
        o_cfg.x_end     = (x_sum > {1'b0, w_eff}) ? {1'b0, w_eff} : x_sum;
        o_cfg.y_end     = {2'b00, r_crop_y} + {1'b0, ch};
        o_cfg.pal_count = r_pal_cnt;
    end

endmodule

### hdl/psu_unfilter.sv
// ============================================================================
// psu_unfilter
// Byte-at-a-time scanline unfilter with prefetched line store and crop test.
// ============================================================================
module psu_unfilter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  logic [1:0]          i_op,
    input  logic [7:0]          i_data_byte,
    input  psu_pkg::t_cfg       i_cfg,
    output psu_pkg::t_pix_evt   o_evt
);

    localparam int PW = psu_pkg::POS_W;
    localparam int RW = psu_pkg::ROW_W;
    localparam int AW = psu_pkg::LINE_AW;

    // Stream position state
    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    logic [RW-1:0] r_row;
    logic [RW-1:0] n_row;
    logic [7:0]    r_filter;
    logic [7:0]    n_filter;
    logic          r_done;
    logic          n_done;
    logic [1:0]    r_k3;
    logic [1:0]    n_k3;
    logic [PW-1:0] r_x3;
    logic [PW-1:0] n_x3;

    logic [7:0] r_left [4];
    logic [7:0] r_ul   [4];
    logic [7:0] r_pix  [3];

    // Line store
    logic [7:0]    r_line [psu_pkg::LINE_DEPTH];
    logic [7:0]    r_line_q;
    logic [PW-1:0] rd_pos;

    logic [PW-1:0] i_idx;
    logic [PW-1:0] x;
    logic [1:0]    k;
    logic          in_row;
    logic          row_end;
    logic          first_px;
    logic          first_row;
    logic          is_data;
    logic          is_filt;
    logic          is_start;
    logic          wr;
    logic          pix_end;
    logic          emit;
    logic          last;
    logic [7:0]    a;
    logic [7:0]    b;
    logic [7:0]    c;
    logic [8:0]    avg_sum;
    logic signed [9:0] d_pa;
    logic signed [9:0] d_pb;
    logic signed [9:0] d_pc;
    logic [9:0]    pa;
    logic [9:0]    pb;
    logic [9:0]    pc;
    logic [7:0]    pred;
    logic [7:0]    v;
    logic [7:0]    pix_nx [3];

    // Byte index decode
    always_comb begin
        i_idx = r_pos - PW'(1);
        case (i_cfg.bpp)
            3'd2: begin
                k = {1'b0, i_idx[0]};
                x = i_idx >> 1;
            end
            3'd3: begin
                k = r_k3;
                x = r_x3;
            end
            3'd4: begin
                k = i_idx[1:0];
                x = i_idx >> 2;
            end
            default: begin
                k = 2'd0;
                x = i_idx;
            end
        endcase
        in_row    = (r_pos <= i_cfg.row_bytes);
        row_end   = (r_pos >= i_cfg.row_bytes);
        first_px  = (x == PW'(0));
        first_row = (r_row == RW'(0));
        pix_end   = (k == 2'(i_cfg.bpp - 3'd1));
    end

    // Predictor
    always_comb begin
        a = first_px ? 8'd0 : r_left[k];
        b = first_row ? 8'd0 : r_line_q;
        c = (first_row || first_px) ? 8'd0 : r_ul[k];

        avg_sum = {1'b0, a} + {1'b0, b};
        d_pa = $signed({2'b00, b}) - $signed({2'b00, c});
        d_pb = $signed({2'b00, a}) - $signed({2'b00, c});
        d_pc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
        pa = (d_pa < 0) ? 10'(-d_pa) : 10'(d_pa);
        pb = (d_pb < 0) ? 10'(-d_pb) : 10'(d_pb);
        pc = (d_pc < 0) ? 10'(-d_pc) : 10'(d_pc);

        case (r_filter)
            psu_pkg::FLT_SUB:   pred = a;
            psu_pkg::FLT_UP:    pred = b;
            psu_pkg::FLT_AVG:   pred = avg_sum[8:1];
            psu_pkg::FLT_PAETH: pred = (pa <= pb && pa <= pc) ? a : ((pb <= pc) ? b : c);
            default:            pred = 8'd0;
        endcase
        v = i_data_byte + pred;
    end

    // Item decode and crop test
    always_comb begin
        is_start = i_acc && (i_op == psu_pkg::OP_START);
        is_filt  = i_acc && (i_op == psu_pkg::OP_STREAM) && !r_done && (r_pos == PW'(0));
        is_data  = i_acc && (i_op == psu_pkg::OP_STREAM) && !r_done && (r_pos != PW'(0));
        wr       = is_data && in_row;

        for (int j = 0; j < 3; j++) begin
            pix_nx[j] = (k == 2'(j)) ? v : r_pix[j];
        end

        emit = wr && pix_end
            && ({1'b0, r_row} >= {2'b00, i_cfg.crop_y})
            && ({1'b0, r_row} < i_cfg.y_end)
            && (x >= PW'(i_cfg.crop_x))
            && (x < PW'(i_cfg.x_end));
        last = (x == PW'(i_cfg.x_end) - PW'(1));

        o_evt.vld  = emit;
        o_evt.pix0 = pix_nx[0];
        o_evt.pix1 = pix_nx[1];
        o_evt.pix2 = pix_nx[2];
        o_evt.col  = 8'(x - PW'(i_cfg.crop_x));
        o_evt.row  = 8'(r_row - RW'(i_cfg.crop_y));
        o_evt.last = last;
        o_evt.done = last && ({1'b0, r_row} == i_cfg.y_end - 10'd1);
    end

    // Next position state
    always_comb begin
        n_pos    = r_pos;
        n_row    = r_row;
        n_filter = r_filter;
        n_done   = r_done;
        n_k3     = r_k3;
        n_x3     = r_x3;
        if (is_start) begin
            n_pos    = PW'(0);
            n_row    = RW'(0);
            n_filter = 8'd0;
            n_done   = 1'b0;
        end else if (is_filt) begin
            n_filter = i_data_byte;
            n_pos    = PW'(1);
            n_k3     = 2'd0;
            n_x3     = PW'(0);
        end else if (is_data) begin
            if (r_k3 == 2'd2) begin
                n_k3 = 2'd0;
                n_x3 = r_x3 + PW'(1);
            end else begin
                n_k3 = r_k3 + 2'd1;
            end
            if (row_end) begin
                n_pos  = PW'(0);
                n_row  = r_row + RW'(1);
                n_done = ({1'b0, n_row} >= i_cfg.y_end);
            end else begin
                n_pos = r_pos + PW'(1);
            end
        end
        rd_pos = n_pos - PW'(1);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_row    <= '0;
            r_filter <= '0;
            r_done   <= 1'b0;
            r_k3     <= '0;
            r_x3     <= '0;
        end else begin
            r_pos    <= n_pos;
            r_row    <= n_row;
            r_filter <= n_filter;
            r_done   <= n_done;
            r_k3     <= n_k3;
            r_x3     <= n_x3;
        end
    end

    // Neighbor and pixel byte registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || is_start) begin
            for (int j = 0; j < 4; j++) begin
                r_left[j] <= 8'd0;
                r_ul[j]   <= 8'd0;
            end
            for (int j = 0; j < 3; j++) begin
                r_pix[j] <= 8'd0;
            end
        end else if (wr) begin
            r_left[k] <= v;
            r_ul[k]   <= b;
            for (int j = 0; j < 3; j++) begin
                r_pix[j] <= pix_nx[j];
            end
        end
    end

    // Line store: write current byte, prefetch the next one
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_line[i_idx[AW-1:0]] <= v;
        end
        r_line_q <= r_line[rd_pos[AW-1:0]];
    end

    // Assertions
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !o_evt.vld)
        else $error("pixel emitted after crop window finished");

    a_mod3_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != PW'(0)) |-> ((PW'(r_x3 * 3) + PW'(r_k3)) == i_idx) && (r_k3 != 2'd3))
        else $error("mod-3 byte counter out of step with byte position");

    a_filter_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_filt |=> (r_pos == PW'(1)))
        else $error("filter byte did not advance to first sample");

endmodule

### hdl/psu_color.sv
// ============================================================================
// psu_color
// Palette store, RGB565 conversion and two-entry output buffer.
// ============================================================================
module psu_color (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psu_pkg::t_pix_evt   i_evt,
    input  psu_pkg::t_pal_wr    i_pal_wr,
    input  psu_pkg::t_cfg       i_cfg,
    output logic                o_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [15:0]         o_pixel565,
    output logic [7:0]          o_out_col,
    output logic [7:0]          o_out_row,
    output logic                o_row_last,
    output logic                o_crop_done
);

    localparam int PA = psu_pkg::PAL_AW;

    // Palette store
    logic [23:0] r_pal [psu_pkg::PALETTE_DEPTH];
    logic [23:0] r_pal_q;

    // Stage 1
    logic       r_s1_vld;
    logic       n_s1_vld;
    logic [7:0] r_s1_pix [3];
    logic [2:0] r_s1_mode;
    logic       r_s1_pal_ok;
    logic [7:0] r_s1_col;
    logic [7:0] r_s1_row;
    logic       r_s1_last;
    logic       r_s1_done;

    // Output register
    logic        r_o_vld;
    logic        n_o_vld;
    logic [15:0] r_o_pixel;
    logic [7:0]  r_o_col;
    logic [7:0]  r_o_row;
    logic        r_o_last;
    logic        r_o_done;

    logic        s1_adv;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] px565;

    // Flow control
    always_comb begin
        s1_adv   = r_s1_vld && (!r_o_vld || i_out_ready);
        o_ready  = !r_s1_vld || s1_adv;
        n_s1_vld = i_evt.vld || (r_s1_vld && !s1_adv);
        n_o_vld  = s1_adv || (r_o_vld && !i_out_ready);
    end

    // Palette write and lookup
    always_ff @(posedge i_clk) begin
        if (i_pal_wr.we && ({1'b0, i_pal_wr.idx} < 9'(psu_pkg::PALETTE_DEPTH))) begin
            r_pal[i_pal_wr.idx[PA-1:0]] <= {i_pal_wr.red, i_pal_wr.green, i_pal_wr.blue};
        end
        if (i_evt.vld) begin
            r_pal_q <= r_pal[i_evt.pix0[PA-1:0]];
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (i_evt.vld) begin
            r_s1_pix[0] <= i_evt.pix0;
            r_s1_pix[1] <= i_evt.pix1;
            r_s1_pix[2] <= i_evt.pix2;
            r_s1_mode   <= i_cfg.mode;
            r_s1_pal_ok <= ({1'b0, i_evt.pix0} < i_cfg.pal_count)
                        && ({1'b0, i_evt.pix0} < 9'(psu_pkg::PALETTE_DEPTH));
            r_s1_col    <= i_evt.col;
            r_s1_row    <= i_evt.row;
            r_s1_last   <= i_evt.last;
            r_s1_done   <= i_evt.done;
        end
    end

    // Color select and conversion
    always_comb begin
        case (r_s1_mode)
            psu_pkg::MODE_RGB,
            psu_pkg::MODE_RGBA: begin
                red   = r_s1_pix[0];
                green = r_s1_pix[1];
                blue  = r_s1_pix[2];
            end
            psu_pkg::MODE_PAL: begin
                red   = r_s1_pal_ok ? r_pal_q[23:16] : 8'd0;
                green = r_s1_pal_ok ? r_pal_q[15:8]  : 8'd0;
                blue  = r_s1_pal_ok ? r_pal_q[7:0]   : 8'd0;
            end
            default: begin
                red   = r_s1_pix[0];
                green = r_s1_pix[0];
                blue  = r_s1_pix[0];
            end
        endcase
        px565 = psu_pkg::to_565(red, green, blue);
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_pixel <= px565;
            r_o_col   <= r_s1_col;
            r_o_row   <= r_s1_row;
            r_o_last  <= r_s1_last;
            r_o_done  <= r_s1_done;
        end
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_o_vld  <= n_o_vld;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_pixel565  = r_o_pixel;
    assign o_out_col   = r_o_col;
    assign o_out_row   = r_o_row;
    assign o_row_last  = r_o_last;
    assign o_crop_done = r_o_done;

    // Assertions
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.vld |-> o_ready)
        else $error("pixel arrived while stage 1 was blocked");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_crop_done) |-> o_row_last)
        else $error("crop_done without row_last");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_o_vld)
        else $error("stage 1 advanced but output register empty");

endmodule

### hdl/png_scanline_unfilter_rgb565_unit.sv
// ============================================================================
// png_scanline_unfilter_rgb565_unit
// PNG scanline unfilter with crop window and RGB565 (byte-swapped) output.
// ============================================================================
//
//  Channel   Signals                                   Direction
//  -------   ---------------------------------------   ---------
//  in        i_in_valid / o_in_ready, i_op, i_data_byte,
//            i_pal_index, i_pal_red/green/blue        sink
//  out       o_out_valid / i_out_ready, o_pixel565,
//            o_out_col, o_out_row, o_row_last,
//            o_crop_done                              source
//  cfg       i_cfg_we, i_cfg_index, i_cfg_data        write only
//
//  One word is taken per clock while o_in_ready is high. Each stream byte is
//  unfiltered in the cycle it is accepted, against a line-store byte
//  prefetched the cycle before. A pixel word reaches the output through the
//  palette lookup register and then the output register.
//  Reset is synchronous; line store and palette are not cleared.
//  o_in_ready drops only while both the lookup stage and the output register
//  hold a word and i_out_ready is low.
// ============================================================================
module png_scanline_unfilter_rgb565_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_pal_index,
    input  logic [7:0]  i_pal_red,
    input  logic [7:0]  i_pal_green,
    input  logic [7:0]  i_pal_blue,
    // output words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_pixel565,
    output logic [7:0]  o_out_col,
    output logic [7:0]  o_out_row,
    output logic        o_row_last,
    output logic        o_crop_done,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    psu_pkg::t_cfg     cfg;
    psu_pkg::t_pix_evt evt;
    psu_pkg::t_pal_wr  pal_wr;
    logic              in_acc;
    logic              col_ready;

    assign o_in_ready = col_ready;
    assign in_acc     = i_in_valid && col_ready;

    // Palette write request
    always_comb begin
        pal_wr.we    = in_acc && (i_op == psu_pkg::OP_PAL_WR);
        pal_wr.idx   = i_pal_index;
        pal_wr.red   = i_pal_red;
        pal_wr.green = i_pal_green;
        pal_wr.blue  = i_pal_blue;
    end

    psu_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    psu_unfilter u_unfilter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (in_acc),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_cfg       (cfg),
        .o_evt       (evt)
    );

    psu_color u_color (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt),
        .i_pal_wr    (pal_wr),
        .i_cfg       (cfg),
        .o_ready     (col_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel565  (o_pixel565),
        .o_out_col   (o_out_col),
        .o_out_row   (o_out_row),
        .o_row_last  (o_row_last),
        .o_crop_done (o_crop_done)
    );

endmodule
